// ===== rtl/tclt_pkg.sv =====
// Shared types and constants for the texture cache slot tracker.
`default_nettype none
package tclt_pkg;

  typedef struct packed {
    logic [31:0] bitmap_key;
    logic [63:0] content_digest;
    logic [15:0] pixel_width;
    logic [15:0] pixel_height;
    logic [5:0]  texture_depth_bits;
    logic [63:0] now_stamp;
    logic [31:0] new_texture_handle;
  } req_t;

  typedef struct packed {
    logic [5:0]  slot_index;
    logic        was_hit;
    logic        upload_needed;
    logic        recreate_needed;
    logic [31:0] active_handle;
    logic        destroy_valid;
    logic [31:0] old_handle_to_destroy;
  } rsp_t;

  // Width of one stored slot record: key, digest, stamp, width, height, depth.
  localparam int unsigned RecW = 32 + 64 + 64 + 16 + 16 + 6;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the request
    logic scan_clr;   // restart the scan counter
    logic scan_rd;    // issue a read at the scan counter
    logic scan_step;  // evaluate returned data and advance
    logic slot_rd;    // read the chosen slot
    logic commit;     // write the slot and form the result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_last;  // scan counter on its final entry
    logic hit;        // key match found
    logic fill_left;  // never-used slots remain
    logic invalid_any;// an invalid slot exists
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/tclt_if.sv =====
// Valid/ready channel carrying one payload.
`default_nettype none
interface tclt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tclt_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module tclt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/tclt_ctrl.sv =====
// Sequencer for the key scan, victim choice and slot update.
`default_nettype none
module tclt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire tclt_pkg::sts_t sts,
  output tclt_pkg::cmd_t     cmd
);
  import tclt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_KRD   = 7'b0000010,
    S_KCHK  = 7'b0000100,
    S_ORD   = 7'b0001000,
    S_OCHK  = 7'b0010000,
    S_SLOT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   oval_r, oval_nxt;

  assign in_ready  = (state_r == S_IDLE) && !oval_r;
  assign out_valid = oval_r;

  always_comb begin
    state_nxt = state_r;
    oval_nxt  = oval_r && !out_ready;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_KRD;
        end
      end
      S_KRD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_KCHK;
      end
      S_KCHK: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          state_nxt = S_SLOT;
        end else if (!sts.scan_last) begin
          state_nxt = S_KRD;
        end else if (sts.fill_left || sts.invalid_any) begin
          state_nxt = S_SLOT;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_ORD;
        end
      end
      S_ORD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_OCHK;
      end
      S_OCHK: begin
        cmd.scan_step = 1'b1;
        state_nxt     = sts.scan_last ? S_SLOT : S_ORD;
      end
      S_SLOT: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        oval_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tclt_dp.sv =====
// Slot table, scan counter, match and oldest-stamp logic, result register.
`default_nettype none
module tclt_dp #(
  parameter int unsigned CACHE_ENTRIES = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tclt_pkg::req_t req,
  input  wire tclt_pkg::cmd_t cmd,
  output tclt_pkg::sts_t      sts,
  output tclt_pkg::rsp_t      rsp
);
  import tclt_pkg::*;

  localparam int unsigned AW = $clog2(CACHE_ENTRIES);
  localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);

  req_t                   req_r;
  logic [AW-1:0]          cnt_r, cnt_nxt;
  logic [AW-1:0]          sel_r, sel_nxt;
  logic                   hit_r, hit_nxt;
  logic                   inv_any_r, inv_any_nxt;
  logic [AW-1:0]          inv_idx_r, inv_idx_nxt;
  logic [63:0]            old_stamp_r, old_stamp_nxt;
  logic [CW-1:0]          fill_r, fill_nxt;
  logic [CACHE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CACHE_ENTRIES-1:0] hvld_r, hvld_nxt;
  logic                   oldphase_r, oldphase_nxt;
  rsp_t                   rsp_r, rsp_nxt;

  logic                   we;
  logic [AW-1:0]          addr;
  logic [RecW-1:0]        wrec, rrec;
  logic [31:0]            hwdata, hrdata;
  logic [31:0]            r_key;
  logic [63:0]            r_dig, r_stamp;
  logic [15:0]            r_w, r_h;
  logic [5:0]             r_d;
  logic                   fill_left;
  logic [31:0]            cur_h;
  logic                   upl, rec;

  assign {r_key, r_dig, r_stamp, r_w, r_h, r_d} = rrec;
  assign wrec = {req_r.bitmap_key, req_r.content_digest, req_r.now_stamp,
                 req_r.pixel_width, req_r.pixel_height, req_r.texture_depth_bits};
  assign fill_left = (fill_r < CW'(CACHE_ENTRIES));
  assign addr = (cmd.slot_rd || cmd.commit) ? sel_r : cnt_r;
  assign we   = cmd.commit;
  // Handle store reads as zero until first written.
  assign cur_h = hvld_r[sel_r] ? hrdata : 32'd0;

  tclt_ram #(.WIDTH(RecW), .DEPTH(CACHE_ENTRIES)) u_rec (
    .clk(clk), .we(we), .addr(addr), .wdata(wrec), .rdata(rrec));
  tclt_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_hdl (
    .clk(clk), .we(we), .addr(addr), .wdata(hwdata), .rdata(hrdata));

  // Status is formed from registers and read data only, never from commands.
  assign sts.scan_last   = (cnt_r == AW'(CACHE_ENTRIES - 1));
  assign sts.hit         = !oldphase_r && valid_r[cnt_r] &&
                           (r_key == req_r.bitmap_key);
  assign sts.fill_left   = fill_left;
  assign sts.invalid_any = inv_any_r || !valid_r[cnt_r];

  always_comb begin
    upl = hit_r ? (req_r.content_digest != r_dig) : 1'b1;
    rec = hit_r ? ((req_r.pixel_width != r_w) || (req_r.pixel_height != r_h) ||
                   (req_r.texture_depth_bits != r_d)) : 1'b1;
    hwdata = rec ? req_r.new_texture_handle : cur_h;
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    hit_nxt       = hit_r;
    inv_any_nxt   = inv_any_r;
    inv_idx_nxt   = inv_idx_r;
    old_stamp_nxt = old_stamp_r;
    oldphase_nxt  = oldphase_r;
    fill_nxt      = fill_r;
    valid_nxt     = valid_r;
    hvld_nxt      = hvld_r;
    rsp_nxt       = rsp_r;
    if (cmd.load) begin
      hit_nxt      = 1'b0;
      inv_any_nxt  = 1'b0;
      oldphase_nxt = 1'b0;
    end
    if (cmd.scan_step) begin
      if (!oldphase_r) begin
        // Highest invalid index wins: later indices overwrite.
        if (!valid_r[cnt_r]) begin
          inv_any_nxt = 1'b1;
          inv_idx_nxt = cnt_r;
        end
        if (sts.hit) begin
          hit_nxt = 1'b1;
          sel_nxt = cnt_r;
        end else if (sts.scan_last) begin
          if (fill_left) begin
            sel_nxt  = fill_r[AW-1:0];
            fill_nxt = fill_r + CW'(1);
          end else if (inv_any_nxt) begin
            sel_nxt = inv_idx_nxt;
          end else begin
            oldphase_nxt = 1'b1;
          end
        end
      end else if (cnt_r == '0 || r_stamp < old_stamp_r) begin
        // Strict compare keeps the lowest index on a tie.
        old_stamp_nxt = r_stamp;
        sel_nxt       = cnt_r;
      end
      cnt_nxt = cnt_r + AW'(1);
    end
    if (cmd.scan_clr) begin
      cnt_nxt = '0;
    end
    if (cmd.commit) begin
      valid_nxt[sel_r] = 1'b1;
      hvld_nxt[sel_r]  = 1'b1;
      rsp_nxt.slot_index            = 6'(sel_r);
      rsp_nxt.was_hit               = hit_r;
      rsp_nxt.upload_needed         = upl;
      rsp_nxt.recreate_needed       = rec;
      rsp_nxt.active_handle         = hwdata;
      rsp_nxt.destroy_valid         = hit_r && rec && (cur_h != 32'd0);
      rsp_nxt.old_handle_to_destroy = (hit_r && rec) ? cur_h : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req;
    end
    cnt_r       <= cnt_nxt;
    sel_r       <= sel_nxt;
    hit_r       <= hit_nxt;
    inv_any_r   <= inv_any_nxt;
    inv_idx_r   <= inv_idx_nxt;
    old_stamp_r <= old_stamp_nxt;
    oldphase_r  <= oldphase_nxt;
    rsp_r       <= rsp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      valid_r <= '0;
      hvld_r  <= '0;
    end else begin
      fill_r  <= fill_nxt;
      valid_r <= valid_nxt;
      hvld_r  <= hvld_nxt;
    end
  end

  assign rsp = rsp_r;
endmodule
`default_nettype wire

// ===== rtl/texture_cache_lru_tracker_core.sv =====
// Top level of the texture cache slot tracker.
`default_nettype none
// Texture cache slot tracker. Each request carries an image key, content
// digest, size, depth, a time stamp and a fresh texture handle; the block
// looks the key up in a fully associative table of CACHE_ENTRIES slots and
// returns one result per request: the slot used, hit, upload and recreate
// flags, the handle now in effect and any old handle to destroy. On a miss
// it takes the next never-used slot, else the highest-numbered invalid
// slot, else the slot with the oldest stamp (lowest index on a tie).
// The key search reads one slot at a time from a single-port RAM and stops
// at a hit; a miss with the table full and no invalid slot then runs a
// second, oldest-stamp scan over the whole table. The result sits in an
// output register; a new request is taken once the previous result has gone.
// No clearing pass is needed after reset.
module texture_cache_lru_tracker_core #(
  parameter int unsigned CACHE_ENTRIES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tclt_if.sink      in_ch,
  tclt_if.source    out_ch
);
  import tclt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;

  // Sequence the scans and hold the handshake.
  tclt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd));

  // Table storage and per-request arithmetic.
  tclt_dp #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .req(in_ch.data), .cmd(cmd), .sts(sts), .rsp(rsp));

  assign out_ch.data = rsp;
endmodule
`default_nettype wire

// ===== tb/tclt_tb_pkg.sv =====
// Slot count shared by the testbench.
package tclt_tb_pkg;
  import tclt_pkg::*;
  localparam int unsigned SLOTS = 64;
endpackage

// ===== tb/tb_texture_cache_lru_tracker_core.sv =====
// Testbench for the texture cache slot tracker: random and directed requests, scoreboard check.
module tb_texture_cache_lru_tracker_core;
  import tclt_pkg::*;
  import tclt_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;

  tclt_if #(.T(req_t)) req_ch ();
  tclt_if #(.T(rsp_t)) rsp_ch ();

  texture_cache_lru_tracker_core #(.CACHE_ENTRIES(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch.sink), .out_ch(rsp_ch.source)
  );

  // Shadow copy of the slot table, kept in step with accepted requests.
  logic        sh_valid [SLOTS];
  logic [31:0] sh_key [SLOTS];
  logic [63:0] sh_digest [SLOTS];
  logic [63:0] sh_stamp [SLOTS];
  logic [15:0] sh_w [SLOTS];
  logic [15:0] sh_h [SLOTS];
  logic [5:0]  sh_depth [SLOTS];
  logic [31:0] sh_handle [SLOTS];
  int unsigned sh_fill;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int unsigned err_count;
  int unsigned hit_count;
  int unsigned evict_count;
  int unsigned rsp_count;
  int unsigned cycle_count;
  bit          stim_done;

  // Key pool kept a little larger than the table so eviction happens often.
  logic [31:0] key_pool [80];
  logic [63:0] stamp_now;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mirror one request into the shadow table and return the expected result.
  function automatic rsp_t lookup_and_update(input req_t r);
    rsp_t        res;
    int          slot;
    bit          found;
    bit          recreate;
    found = 1'b0;
    slot = 0;
    res = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && sh_valid[i] && sh_key[i] == r.bitmap_key) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (!found) begin
      if (sh_fill < SLOTS) begin
        slot = sh_fill;
        sh_fill++;
      end else begin
        slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (slot < 0 && !sh_valid[i]) slot = i;
        if (slot < 0) begin
          slot = 0;
          for (int i = 1; i < SLOTS; i++)
            if (sh_stamp[i] < sh_stamp[slot]) slot = i;
          evict_count++;
        end
      end
      sh_valid[slot] = 1'b1;
      sh_key[slot] = r.bitmap_key;
      sh_handle[slot] = '0;
      res.upload_needed = 1'b1;
      recreate = 1'b1;
    end else begin
      hit_count++;
      res.upload_needed = (r.content_digest != sh_digest[slot]);
      recreate = (r.pixel_width != sh_w[slot]) || (r.pixel_height != sh_h[slot]) ||
                 (r.texture_depth_bits != sh_depth[slot]);
    end
    if (recreate) begin
      if (sh_handle[slot] != 0) begin
        res.destroy_valid = 1'b1;
        res.old_handle_to_destroy = sh_handle[slot];
      end
      sh_handle[slot] = r.new_texture_handle;
    end
    sh_digest[slot] = r.content_digest;
    sh_stamp[slot] = r.now_stamp;
    sh_w[slot] = r.pixel_width;
    sh_h[slot] = r.pixel_height;
    sh_depth[slot] = r.texture_depth_bits;
    res.slot_index = slot[5:0];
    res.was_hit = found;
    res.recreate_needed = recreate;
    res.active_handle = sh_handle[slot];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    $display("mismatch %s at result %0d: got %0h want %0h", what, rsp_count, got, want);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // Build a request stamped with the current stamp_now and append it to the queue.
  task automatic queue_req(input logic [31:0] key, input logic [63:0] dig,
                           input logic [15:0] w, input logic [15:0] h,
                           input logic [5:0] d, input logic [31:0] hdl);
    req_t r;
    r.bitmap_key = key;
    r.content_digest = dig;
    r.pixel_width = w;
    r.pixel_height = h;
    r.texture_depth_bits = d;
    r.now_stamp = stamp_now;
    r.new_texture_handle = hdl;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Stimulus: directed corners, then mostly reuse of a bounded key pool.
  initial begin
    logic [31:0] k;
    int unsigned p;
    int unsigned mode;
    stamp_now = 64'd0;
    for (int i = 0; i < 80; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    // Field extremes, a miss, then hits that keep, re-upload and recreate.
    queue_req(32'h0, 64'h0, 16'h0, 16'h0, 6'd0, 32'h1);
    queue_req(32'h0, 64'h0, 16'h0, 16'h0, 6'd0, 32'h2);
    queue_req(32'h0, '1, 16'h0, 16'h0, 6'd0, 32'h3);
    queue_req(32'h0, '1, 16'hFFFF, 16'hFFFF, 6'd32, 32'hFFFF_FFFF);
    queue_req(32'h0, '1, 16'hFFFF, 16'hFFFF, 6'd63, 32'h0);
    // Zero handle held: a recreate reports no destroy.
    queue_req(32'h0, '1, 16'h1, 16'hFFFF, 6'd63, 32'h5);
    stamp_now = '1;
    queue_req(32'hFFFF_FFFF, '1, 16'hFFFF, 16'h0, 6'd16, 32'hA5A5_5A5A);
    queue_req(32'hFFFF_FFFF, 64'h1, 16'hFFFF, 16'h1, 6'd16, 32'h5A5A_A5A5);
    stamp_now = 64'd10;
    // Equal stamps on most slots once the table fills, so a tie picks the lowest index.
    for (int i = 0; i < 66; i++)
      queue_req(32'h1000 + i, rand64(), 16'd8, 16'd8, 6'd32, 32'h100 + i);
    for (int n = 0; n < 2000; n++) begin
      stamp_now = stamp_now + $urandom_range(0, 3);
      mode = $urandom_range(0, 9);
      p = $urandom_range(0, 79);
      k = (mode == 0) ? $urandom() : key_pool[p];
      queue_req(k, (mode < 6) ? {32'h0, 28'h0, p[3:0]} : rand64(),
                (mode < 7) ? 16'd64 : 16'($urandom()),
                (mode < 7) ? 16'd32 : 16'($urandom()),
                (mode < 7) ? 6'd24 : 6'($urandom_range(0, 63)),
                ($urandom_range(0, 30) == 0) ? 32'h0 : $urandom());
    end
  end

  // Hold reset, then release it once.
  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Request driver: hold valid until accepted, insert random gaps between requests.
  int unsigned drv_gap;
  int unsigned out_gap;
  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    drv_gap = 0;
    out_gap = 0;
    sh_fill = 0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_valid[i] = 1'b0;
      sh_handle[i] = '0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_ch.ready) begin
      // hold the request
    end else begin
      if (req_ch.valid) begin
        expected_rsps.insert(expected_rsps.size(), lookup_and_update(req_ch.data));
        drv_gap = gap_len();
      end
      if (drv_gap == 0 && pending_reqs.size() != 0) begin
        req_ch.data <= pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
        if (drv_gap != 0) drv_gap--;
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected result", got.slot_index, 0);
        end else begin
          want = expected_rsps.pop_front();
          if (got.slot_index !== want.slot_index)
            report_mismatch("slot_index", got.slot_index, want.slot_index);
          if (got.was_hit !== want.was_hit)
            report_mismatch("was_hit", got.was_hit, want.was_hit);
          if (got.upload_needed !== want.upload_needed)
            report_mismatch("upload_needed", got.upload_needed, want.upload_needed);
          if (got.recreate_needed !== want.recreate_needed)
            report_mismatch("recreate_needed", got.recreate_needed, want.recreate_needed);
          if (got.active_handle !== want.active_handle)
            report_mismatch("active_handle", got.active_handle, want.active_handle);
          if (got.destroy_valid !== want.destroy_valid)
            report_mismatch("destroy_valid", got.destroy_valid, want.destroy_valid);
          if (got.old_handle_to_destroy !== want.old_handle_to_destroy)
            report_mismatch("old_handle_to_destroy", got.old_handle_to_destroy,
                            want.old_handle_to_destroy);
        end
        rsp_count++;
        out_gap = gap_len();
      end
      // stall after a result: mostly short, now and then a long stretch low
      if (out_gap != 0) begin
        rsp_ch.ready <= 1'b0;
        out_gap--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // End of run: drain the queues, then wait before deciding.
  initial begin
    err_count = 0;
    hit_count = 0;
    evict_count = 0;
    rsp_count = 0;
    cycle_count = 0;
    stim_done = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (4 * SLOTS + 20) @(posedge clk);
    stim_done = 1'b1;
    $display("%0d results checked, %0d hits, %0d oldest-stamp evictions", rsp_count,
             hit_count, evict_count);
    if (err_count == 0 && expected_rsps.size() == 0) begin
      $display("tb_texture_cache_lru_tracker_core: clean");
    end else begin
      $display("tb_texture_cache_lru_tracker_core: errors");
    end
    $finish;
  end

  // Watchdog: end the run with errors if the stimulus is not done by the cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!stim_done && cycle_count > 4000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_texture_cache_lru_tracker_core: errors");
      $finish;
    end
  end

endmodule
